FILE: rtl/lr_pkg.sv
// types, widths and codes shared by the line rasterizer modules
package lr_pkg;

  localparam int COORD_BITS  = 10;
  localparam int FIELD_BITS  = 10;
  localparam int COLOR_BITS  = 16;
  localparam int ACC_BITS    = COORD_BITS + 1;
  localparam int CNT_BITS    = COORD_BITS + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = QPTR_BITS + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [FIELD_BITS-1:0] field_t;
  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic [ACC_BITS-1:0]   acc_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [QPTR_BITS-1:0]  qptr_t;
  typedef logic [QCNT_BITS-1:0]  qcnt_t;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_kind_t;

  typedef struct packed {
    req_kind_t req_type;
    field_t    start_x;
    field_t    start_y;
    field_t    end_x;
    field_t    end_y;
    color_t    line_color;
  } in_beat_t;

  typedef struct packed {
    field_t pixel_x;
    field_t pixel_y;
    color_t pixel_color;
    logic   last_pixel;
  } out_beat_t;

  typedef struct packed {
    logic   is_start;
    coord_t x0;
    coord_t y0;
    logic   x_backward;
    logic   y_backward;
    coord_t x_span;
    coord_t y_span;
    coord_t major_span;
    color_t color;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/lr_front.sv
// front end: accepts request beats and turns them into queue commands, with line setup for starts
module lr_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  lr_pkg::in_beat_t req_beat,
  input  lr_pkg::q_stat_t  q_stat,
  output logic             push,
  output lr_pkg::cmd_t     push_cmd
);

  lr_pkg::coord_t sx, sy, ex, ey;
  logic           xb, yb;
  lr_pkg::coord_t xs, ys;

  always_comb begin
    sx = lr_pkg::coord_t'(req_beat.start_x);
    sy = lr_pkg::coord_t'(req_beat.start_y);
    ex = lr_pkg::coord_t'(req_beat.end_x);
    ey = lr_pkg::coord_t'(req_beat.end_y);
    xb = !(ex > sx);
    yb = !(ey > sy);
    xs = xb ? (sx - ex) : (ex - sx);
    ys = yb ? (sy - ey) : (ey - sy);

    push_cmd.is_start   = (req_beat.req_type == lr_pkg::REQ_START);
    push_cmd.x0         = sx;
    push_cmd.y0         = sy;
    push_cmd.x_backward = xb;
    push_cmd.y_backward = yb;
    push_cmd.x_span     = xs;
    push_cmd.y_span     = ys;
    push_cmd.major_span = (xs > ys) ? xs : ys;
    push_cmd.color      = req_beat.line_color;
  end

  assign req_ready = !q_stat.full;
  assign push      = req_valid && !q_stat.full;

`ifndef SYNTH
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full) else $error("push into full queue");
  a_start_major: assert property (@(posedge clk) disable iff (rst)
    push && push_cmd.is_start |->
      push_cmd.major_span >= push_cmd.x_span && push_cmd.major_span >= push_cmd.y_span)
    else $error("major span below an axis span");
  a_back_zero_span: assert property (@(posedge clk) disable iff (rst)
    push && push_cmd.is_start && !push_cmd.x_backward |-> push_cmd.x_span != '0)
    else $error("forward axis with zero span");
`endif

endmodule

FILE: rtl/lr_queue.sv
// small command queue between front and back
module lr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lr_pkg::cmd_t    push_cmd,
  input  logic            pop,
  output lr_pkg::cmd_t    head_cmd,
  output lr_pkg::q_stat_t q_stat
);

  lr_pkg::cmd_t  mem [lr_pkg::QUEUE_DEPTH];
  lr_pkg::qptr_t wptr, rptr;
  lr_pkg::qcnt_t count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + lr_pkg::qptr_t'(1);
      if (pop) rptr <= rptr + lr_pkg::qptr_t'(1);
      if (push && !pop) count <= count + lr_pkg::qcnt_t'(1);
      else if (pop && !push) count <= count - lr_pkg::qcnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_cmd;
  end

  assign head_cmd     = mem[rptr];
  assign q_stat.full  = (count == lr_pkg::qcnt_t'(lr_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);

`ifndef SYNTH
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty) else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + lr_pkg::qcnt_t'(1))
    else $error("queue count did not rise");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    !q_stat.full |-> lr_pkg::qptr_t'(wptr - rptr) == lr_pkg::qptr_t'(count))
    else $error("pointers disagree with count");
`endif

endmodule

FILE: rtl/lr_back.sv
// back end: line state, error accumulators and the pixel output register
module lr_back (
  input  logic              clk,
  input  logic              rst,
  input  lr_pkg::cmd_t      head_cmd,
  input  lr_pkg::q_stat_t   q_stat,
  output logic              pop,
  output logic              pix_valid,
  input  logic              pix_ready,
  output lr_pkg::out_beat_t pix_beat
);

  lr_pkg::coord_t cur_x, cur_y, x_span, y_span, major_span;
  logic           x_backward, y_backward, line_active;
  lr_pkg::acc_t   x_accum, y_accum;
  lr_pkg::cnt_t   points_left;
  lr_pkg::color_t held_color;

  lr_pkg::coord_t bx, by, bxs, bys, bmaj, cur_x_next, cur_y_next;
  logic           bxb, byb, load, line_active_next;
  lr_pkg::acc_t   bxa, bya, x_sum, y_sum, x_accum_next, y_accum_next;
  lr_pkg::cnt_t   bcnt, points_left_next;
  lr_pkg::color_t bcol;

  always_comb begin
    pop  = !q_stat.empty && (!pix_valid || pix_ready);
    load = pop && (head_cmd.is_start || line_active);

    if (head_cmd.is_start) begin
      bx   = head_cmd.x0;
      by   = head_cmd.y0;
      bxb  = head_cmd.x_backward;
      byb  = head_cmd.y_backward;
      bxs  = head_cmd.x_span;
      bys  = head_cmd.y_span;
      bmaj = head_cmd.major_span;
      bxa  = '0;
      bya  = '0;
      bcnt = {1'b0, head_cmd.major_span} + lr_pkg::cnt_t'(1);
      bcol = head_cmd.color;
    end else begin
      bx   = cur_x;
      by   = cur_y;
      bxb  = x_backward;
      byb  = y_backward;
      bxs  = x_span;
      bys  = y_span;
      bmaj = major_span;
      bxa  = x_accum;
      bya  = y_accum;
      bcnt = points_left;
      bcol = held_color;
    end

    x_sum        = bxa + {1'b0, bxs};
    y_sum        = bya + {1'b0, bys};
    x_accum_next = x_sum;
    y_accum_next = y_sum;
    cur_x_next   = bx;
    cur_y_next   = by;
    if (x_sum >= {1'b0, bmaj}) begin
      x_accum_next = x_sum - {1'b0, bmaj};
      cur_x_next   = bxb ? (bx - lr_pkg::coord_t'(1)) : (bx + lr_pkg::coord_t'(1));
    end
    if (y_sum >= {1'b0, bmaj}) begin
      y_accum_next = y_sum - {1'b0, bmaj};
      cur_y_next   = byb ? (by - lr_pkg::coord_t'(1)) : (by + lr_pkg::coord_t'(1));
    end
    points_left_next = (bcnt != '0) ? (bcnt - lr_pkg::cnt_t'(1)) : bcnt;
    line_active_next = (points_left_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      points_left <= '0;
      pix_valid   <= 1'b0;
    end else begin
      if (load) begin
        line_active <= line_active_next;
        points_left <= points_left_next;
        pix_valid   <= 1'b1;
      end else if (pix_ready) begin
        pix_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      x_backward <= bxb;
      y_backward <= byb;
      x_span     <= bxs;
      y_span     <= bys;
      major_span <= bmaj;
      x_accum    <= x_accum_next;
      y_accum    <= y_accum_next;
      held_color <= bcol;
      pix_beat.pixel_x     <= lr_pkg::field_t'(bx);
      pix_beat.pixel_y     <= lr_pkg::field_t'(by);
      pix_beat.pixel_color <= bcol;
      pix_beat.last_pixel  <= (bcnt == lr_pkg::cnt_t'(1));
    end
  end

`ifndef SYNTH
  a_active_count: assert property (@(posedge clk) disable iff (rst)
    line_active == (points_left != '0)) else $error("active flag and count disagree");
  a_accum_bound: assert property (@(posedge clk) disable iff (rst)
    line_active |-> x_accum < {1'b0, major_span} && y_accum < {1'b0, major_span})
    else $error("accumulator reached major span");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    line_active |-> points_left <= {1'b0, major_span})
    else $error("points left beyond line length");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    load && bcnt == lr_pkg::cnt_t'(1) |=> !line_active)
    else $error("line still active after last point");
`endif

endmodule

FILE: rtl/line_rasterizer_unit.sv
// line rasterizer top level: front end, command queue and back end
//
//   channel  signals                          beat
//   req      req_valid / req_ready            lr_pkg::in_beat_t  (start or step)
//   pix      pix_valid / pix_ready            lr_pkg::out_beat_t (one point)
//
// one request beat per cycle while the queue is not full; one point per cycle
// out of the back end while pix is not stalled and the queue holds a command
// the four-entry queue lets req keep flowing while pix is stalled, until it fills
// rst is synchronous; it empties the queue and drops any active line
module line_rasterizer_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  lr_pkg::in_beat_t  req_beat,
  output logic              pix_valid,
  input  logic              pix_ready,
  output lr_pkg::out_beat_t pix_beat
);

  lr_pkg::q_stat_t q_stat;
  lr_pkg::cmd_t    push_cmd, head_cmd;
  logic            push, pop;

  lr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_beat  (req_beat),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  lr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  lr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_cmd  (head_cmd),
    .q_stat    (q_stat),
    .pop       (pop),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix_beat  (pix_beat)
  );

endmodule
